// ----- hw/rtl/atr_pkg.sv -----
package atr_pkg;

  // Price and configuration widths.
  localparam int unsigned PRICE_BITS   = 32;
  localparam int unsigned PERIOD_BITS  = 11;
  localparam int unsigned MAX_PERIOD   = 1024;
  localparam int unsigned PERIOD_RESET = 14;

  // The warm-up sum wraps at 64 bits, so the dividend path is that wide.
  localparam int unsigned SUM_BITS = 64;

  // The divider retires two quotient bits per cycle.
  localparam int unsigned DIV_STEPS     = SUM_BITS / 2;
  localparam int unsigned DIV_CNT_BITS  = $clog2(DIV_STEPS);

  // Depth of the queue between the classifier and the divider.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // What the back end has to do with a bar.
  typedef enum logic [1:0] {
    OP_PASS,    // no new ATR: first bar or warm-up bar
    OP_MEAN,    // last warm-up bar: sum divided by period
    OP_SMOOTH   // Wilder smoothing step
  } atr_op_e;

  typedef struct packed {
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] close_price;
    logic                  new_series;
  } atr_in_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] true_range;
    logic                  range_valid;
    logic [PRICE_BITS-1:0] atr_value;
    logic                  atr_valid;
  } atr_out_t;

  // One classified bar on its way to the back end.
  typedef struct packed {
    atr_op_e                op;
    logic                   clear;
    logic [PERIOD_BITS-1:0] period;
    logic [PRICE_BITS-1:0]  tr;
    logic                   tr_ok;
    logic [SUM_BITS-1:0]    sum;
  } atr_item_t;

endpackage

// ----- hw/rtl/atr_front.sv -----
module atr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [atr_pkg::PERIOD_BITS-1:0] period_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  atr_pkg::atr_in_t               in_data_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output atr_pkg::atr_item_t             q_item_o
);
  import atr_pkg::*;

  logic [PRICE_BITS-1:0]  prev_close_q, prev_close_d;
  logic [PERIOD_BITS-1:0] count_q, count_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;

  logic [PERIOD_BITS-1:0] p_eff;
  logic [PERIOD_BITS-1:0] cnt;
  logic [PRICE_BITS-1:0]  prev;
  logic [SUM_BITS-1:0]    sum_base;
  logic [PRICE_BITS-1:0]  hl, g_hi, g_lo, tr_max, tr_ab;
  logic [PERIOD_BITS-1:0] cnt_inc, p_inc;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Clamp the configured period to the supported window.
  always_comb begin
    if (period_i == '0) begin
      p_eff = PERIOD_BITS'(1);
    end else if (period_i > PERIOD_BITS'(MAX_PERIOD)) begin
      p_eff = PERIOD_BITS'(MAX_PERIOD);
    end else begin
      p_eff = period_i;
    end
  end

  // A new series starts from cleared state.
  assign cnt      = in_data_i.new_series ? '0 : count_q;
  assign prev     = in_data_i.new_series ? '0 : prev_close_q;
  assign sum_base = in_data_i.new_series ? '0 : sum_q;

  // True range: widest of the bar span and the two gaps to the previous close.
  always_comb begin
    hl     = (in_data_i.high_price >= in_data_i.low_price) ?
             (in_data_i.high_price - in_data_i.low_price) : '0;
    g_hi   = (in_data_i.high_price >= prev) ?
             (in_data_i.high_price - prev) : (prev - in_data_i.high_price);
    g_lo   = (in_data_i.low_price >= prev) ?
             (in_data_i.low_price - prev) : (prev - in_data_i.low_price);
    tr_ab  = (g_hi > hl) ? g_hi : hl;
    tr_max = (g_lo > tr_ab) ? g_lo : tr_ab;
  end

  // Classify the bar and advance the series state.
  always_comb begin
    q_item_o.clear  = in_data_i.new_series;
    q_item_o.period = p_eff;
    q_item_o.tr     = '0;
    q_item_o.tr_ok  = 1'b0;
    q_item_o.op     = OP_PASS;
    sum_d           = sum_base;
    if (cnt != '0) begin
      q_item_o.tr    = tr_max;
      q_item_o.tr_ok = 1'b1;
      if (cnt <= p_eff) begin
        sum_d = sum_base + SUM_BITS'(tr_max);
        if (cnt == p_eff) begin
          q_item_o.op = OP_MEAN;
        end
      end else begin
        q_item_o.op = OP_SMOOTH;
      end
    end
    q_item_o.sum = sum_d;
    cnt_inc      = cnt + PERIOD_BITS'(1);
    p_inc        = p_eff + PERIOD_BITS'(1);
    count_d      = (cnt_inc > p_inc) ? p_inc : cnt_inc;
    prev_close_d = in_data_i.close_price;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_close_q <= '0;
      count_q      <= '0;
      sum_q        <= '0;
    end else if (q_push_o) begin
      prev_close_q <= prev_close_d;
      count_q      <= count_d;
      sum_q        <= sum_d;
    end
  end

endmodule

// ----- hw/rtl/atr_queue.sv -----
module atr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  atr_pkg::atr_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output atr_pkg::atr_item_t pop_item_o
);
  import atr_pkg::*;

  atr_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wptr_q, rptr_q;
  logic [QCNT_BITS-1:0]  cnt_q;

  assign full_o     = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rptr_q];

  // Storage for queued bars.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_BITS'(1);
      end
    end
  end

  // The front end never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("queue written while full");

  // The back end never reads an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("queue read while empty");

endmodule

// ----- hw/rtl/atr_back.sv -----
module atr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  atr_pkg::atr_item_t q_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output atr_pkg::atr_out_t  out_data_o
);
  import atr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] rem;
    logic [SUM_BITS-1:0]    dq;
  } div_state_t;

  logic [2:0]              state_q, state_d;
  atr_item_t               item_q;
  logic [PRICE_BITS-1:0]   atr_q;
  logic [SUM_BITS-1:0]     dq_q;
  logic [PERIOD_BITS-1:0]  rem_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    out_valid_q;
  atr_out_t                out_data_q;

  logic [PERIOD_BITS-1:0]            pm1;
  logic [PRICE_BITS+PERIOD_BITS-1:0] prod;
  div_state_t                        st0, st1, st2;
  logic                              out_free;
  logic                              out_load;

  // One restoring step: shift in a dividend bit, subtract the period if it fits.
  function automatic div_state_t div_step(input div_state_t s, input logic [PERIOD_BITS-1:0] d);
    logic [PERIOD_BITS:0] r2;
    logic                 qb;
    div_state_t           res;
    r2 = {s.rem, s.dq[SUM_BITS-1]};
    qb = 1'b0;
    if (r2 >= {1'b0, d}) begin
      r2 = r2 - {1'b0, d};
      qb = 1'b1;
    end
    res.rem = r2[PERIOD_BITS-1:0];
    res.dq  = {s.dq[SUM_BITS-2:0], qb};
    return res;
  endfunction

  assign pm1  = item_q.period - PERIOD_BITS'(1);
  assign prod = atr_q * pm1;

  assign st0.rem = rem_q;
  assign st0.dq  = dq_q;
  assign st1     = div_step(st0, item_q.period);
  assign st2     = div_step(st1, item_q.period);

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_FIN) && out_free;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;

  // Sequencer over the multiply, add and divide steps.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          unique case (q_item_i.op)
            OP_MEAN:   state_d = S_DIV;
            OP_SMOOTH: state_d = S_MUL;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_MUL: state_d = S_ADD;
      S_ADD: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      atr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (q_pop_o && q_item_i.clear) begin
        atr_q <= '0;
      end
      if (state_q == S_DIV) begin
        cnt_q <= cnt_q + DIV_CNT_BITS'(1);
        if (state_d == S_FIN) begin
          atr_q <= st2.dq[PRICE_BITS-1:0];
        end
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      dq_q   <= q_item_i.sum;
      rem_q  <= '0;
    end else if (state_q == S_MUL) begin
      dq_q <= SUM_BITS'(prod);
    end else if (state_q == S_ADD) begin
      dq_q  <= dq_q + SUM_BITS'(item_q.tr);
      rem_q <= '0;
    end else if (state_q == S_DIV) begin
      dq_q  <= st2.dq;
      rem_q <= st2.rem;
    end
  end

  // Result register; it frees the sequencer while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.true_range  <= item_q.tr;
      out_data_q.range_valid <= item_q.tr_ok;
      out_data_q.atr_valid   <= (item_q.op != OP_PASS);
      out_data_q.atr_value   <= (item_q.op != OP_PASS) ? atr_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The partial remainder always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_DIV) |-> (rem_q < item_q.period))
    else $error("divider remainder out of range");

  // An ATR is only reported on a bar that also has a true range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> (!out_data_q.atr_valid || out_data_q.range_valid))
    else $error("ATR reported without true range");

  // The last divide step always hands over to the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ((state_q == S_DIV) && (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)))
                   |=> (state_q == S_FIN))
    else $error("divider did not finish");

endmodule

// ----- hw/rtl/average_true_range_unit.sv -----
// Wilder average true range over a stream of price bars (unsigned Q16.16). Each
// bar transfer yields exactly one result transfer, in order. The first bar of a
// series gives no true range; bars two to period+1 build a warm-up sum, bar
// period+1 reports the truncated mean, and every later bar reports
// (atr*(period-1)+tr)/period, truncated. A classifier takes one bar per cycle
// into a two-entry queue while it is not full; a serial divider that retires
// two quotient bits a cycle over a 64-bit dividend sets the rate, and the back
// end takes a bar only once it is through with the last. The period register
// (reset 14, zero read as 1, values above 1024 read as 1024) may be written
// only while no bar is in flight; raise new_series after changing it.
module average_true_range_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [atr_pkg::PERIOD_BITS-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  atr_pkg::atr_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output atr_pkg::atr_out_t               out_data_o
);
  import atr_pkg::*;

  logic [PERIOD_BITS-1:0] period_q;
  logic                   q_push, q_full, q_pop, q_empty;
  atr_item_t              push_item, pop_item;

  // Period configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_BITS'(PERIOD_RESET);
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  atr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .period_i   (period_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  atr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (pop_item)
  );

  atr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_item_i    (pop_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
